// ===== hdl/rlepd_pkg.sv =====
// shared constants, character codes and transaction types for the run-length pattern decoder
// no dependencies; compiled first
package rlepd_pkg;

    // default coordinate width and fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int LIMIT_W        = 16;
    localparam int OUT_W          = 16;
    localparam int CHAR_W         = 8;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = 8'd1;

    // pattern characters
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_DEAD    = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_EOL     = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_STOP    = 8'h21;  // '!'
    localparam logic [CHAR_W-1:0] CH_LIVE    = 8'h6F;  // 'o'
    localparam logic [CHAR_W-1:0] CH_LOW_Y   = 8'h79;  // 'y'
    localparam logic [CHAR_W-1:0] CH_LOW_P   = 8'h70;  // 'p'
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;  // 'X'

    // one run of live cells
    typedef struct packed {
        logic [OUT_W-1:0] run_row;
        logic [OUT_W-1:0] run_column;
        logic [OUT_W-1:0] run_length;
    } t_run;

    // decoder status towards the output buffer
    typedef struct packed {
        logic produce;
        t_run run;
    } t_step_result;

endpackage

// ===== hdl/rlepd_char_if.sv =====
// character input channel of the run-length pattern decoder
// depends on rlepd_pkg
interface rlepd_char_if import rlepd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              first;

    modport source (output valid, output char_code, output first, input ready);
    modport sink   (input valid, input char_code, input first, output ready);
endinterface

// ===== hdl/rlepd_run_if.sv =====
// run output channel of the run-length pattern decoder
// depends on rlepd_pkg
interface rlepd_run_if import rlepd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] run_row;
    logic [OUT_W-1:0] run_column;
    logic [OUT_W-1:0] run_length;

    modport source (output valid, output run_row, output run_column, output run_length,
                    input ready);
    modport sink   (input valid, input run_row, input run_column, input run_length,
                    output ready);
endinterface

// ===== hdl/rlepd_cfg_if.sv =====
// configuration write channel of the run-length pattern decoder
// depends on rlepd_pkg
interface rlepd_cfg_if import rlepd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rlepd_step.sv =====
// pattern state registers and combinational character decode
// depends on rlepd_pkg
module rlepd_step import rlepd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_first,
    input  logic [LIMIT_W-1:0] i_row_limit,
    input  logic [LIMIT_W-1:0] i_column_limit,
    output t_step_result       o_result
);

    localparam int CB = COORD_BITS;
    localparam int XW = ((CB > LIMIT_W) ? CB : LIMIT_W) + 1;
    localparam int PW = CB + 4;

    logic [CB-1:0] r_repeat_count, n_repeat_count;
    logic [CB-1:0] r_column_pos, n_column_pos;
    logic [CB-1:0] r_row_pos, n_row_pos;
    logic          r_swallow_letter, n_swallow_letter;
    logic          r_stopped, n_stopped;

    logic [CB-1:0] eff_count, eff_col, eff_row;
    logic          eff_swallow, eff_stopped;

    logic          is_digit, is_upper, is_lower_run, is_run, is_dead, is_eol, is_stop;
    logic [3:0]    digit;
    logic [PW-1:0] count_prod;
    logic [CB-1:0] count_sat, n_val, col_sat, row_sat;
    logic [CB:0]   col_sum, row_sum;
    logic [XW-1:0] col_x, row_x, n_x, rlim_x, clim_x, room_x, len_x;
    logic          row_ok;

    // a first character starts from a cleared pattern state
    assign eff_count   = i_first ? '0 : r_repeat_count;
    assign eff_col     = i_first ? '0 : r_column_pos;
    assign eff_row     = i_first ? '0 : r_row_pos;
    assign eff_swallow = i_first ? 1'b0 : r_swallow_letter;
    assign eff_stopped = i_first ? 1'b0 : r_stopped;

    // character classes
    assign is_digit     = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_upper     = (i_char_code >= CH_UPPER_A) && (i_char_code <= CH_UPPER_X);
    assign is_lower_run = (i_char_code >= CH_LOW_P) && (i_char_code <= CH_LOW_Y);
    assign is_run       = is_upper || ((i_char_code >= CH_LIVE) && (i_char_code <= CH_LOW_Y));
    assign is_dead      = (i_char_code == CH_DEAD) || (i_char_code == CH_DOT);
    assign is_eol       = (i_char_code == CH_EOL);
    assign is_stop      = (i_char_code == CH_STOP);

    // count times ten plus digit, saturating
    assign digit      = 4'(i_char_code - CH_ZERO);
    assign count_prod = PW'({eff_count, 3'b000}) + PW'({eff_count, 1'b0}) + PW'(digit);
    assign count_sat  = (|count_prod[PW-1:CB]) ? '1 : count_prod[CB-1:0];

    // effective repeat and saturating position advances
    assign n_val   = (eff_count == '0) ? CB'(1) : eff_count;
    assign col_sum = {1'b0, eff_col} + {1'b0, n_val};
    assign row_sum = {1'b0, eff_row} + {1'b0, n_val};
    assign col_sat = col_sum[CB] ? '1 : col_sum[CB-1:0];
    assign row_sat = row_sum[CB] ? '1 : row_sum[CB-1:0];

    // run clipping against the column limit and the top of the coordinate range
    assign col_x  = XW'(eff_col);
    assign row_x  = XW'(eff_row);
    assign n_x    = XW'(n_val);
    assign rlim_x = XW'(i_row_limit);
    assign clim_x = XW'(i_column_limit);
    assign room_x = (XW'(1) << CB) - col_x;
    assign row_ok = (rlim_x == '0) || (row_x < rlim_x);

    always_comb begin
        len_x = n_x;
        if (clim_x != '0) begin
            if (col_x >= clim_x) begin
                len_x = '0;
            end else if (len_x > (clim_x - col_x)) begin
                len_x = clim_x - col_x;
            end
        end
        if (len_x > room_x) begin
            len_x = room_x;
        end
    end

    // next state and result
    always_comb begin
        n_repeat_count            = eff_count;
        n_column_pos              = eff_col;
        n_row_pos                 = eff_row;
        n_swallow_letter          = eff_swallow;
        n_stopped                 = eff_stopped;
        o_result.produce          = 1'b0;
        o_result.run.run_row      = row_x[OUT_W-1:0];
        o_result.run.run_column   = col_x[OUT_W-1:0];
        o_result.run.run_length   = len_x[OUT_W-1:0];
        if (!eff_stopped) begin
            n_swallow_letter = 1'b0;
            if (!(eff_swallow && is_upper)) begin
                if (is_digit) begin
                    n_repeat_count = count_sat;
                end else begin
                    n_repeat_count = '0;
                    if (is_dead) begin
                        n_column_pos = col_sat;
                    end else if (is_eol) begin
                        n_column_pos = '0;
                        n_row_pos    = row_sat;
                    end else if (is_stop) begin
                        n_stopped = 1'b1;
                    end else if (is_run) begin
                        if (is_lower_run) begin
                            n_swallow_letter = 1'b1;
                        end
                        if (row_ok) begin
                            o_result.produce = (len_x != '0);
                            n_column_pos     = col_sat;
                        end
                    end
                end
            end
        end
    end

    // state registers, updated once per accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_count   <= '0;
            r_column_pos     <= '0;
            r_row_pos        <= '0;
            r_swallow_letter <= 1'b0;
            r_stopped        <= 1'b0;
        end else if (i_advance) begin
            r_repeat_count   <= n_repeat_count;
            r_column_pos     <= n_column_pos;
            r_row_pos        <= n_row_pos;
            r_swallow_letter <= n_swallow_letter;
            r_stopped        <= n_stopped;
        end
    end

endmodule

// ===== hdl/rlepd_out_buf.sv =====
// two-entry result buffer: output register plus skid entry
// depends on rlepd_pkg
module rlepd_out_buf import rlepd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_run o_data
);

    logic [1:0] r_count, n_count;
    t_run       r_entry [2];
    logic [1:0] slot;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_entry[0];

    // slot taken by a new run once the head has been popped
    assign slot    = r_count - {1'b0, i_pop};
    assign n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // payload entries, no reset; head takes the new run or the skid entry
    always_ff @(posedge i_clk) begin
        if (i_push && (slot == 2'd0)) begin
            r_entry[0] <= i_data;
        end else if (i_pop) begin
            r_entry[0] <= r_entry[1];
        end
        if (i_push && (slot == 2'd1)) begin
            r_entry[1] <= i_data;
        end
    end

endmodule

// ===== hdl/rle_pattern_run_decoder.sv =====
// top level of the run-length pattern decoder
// depends on rlepd_pkg, the channel interfaces, rlepd_step and rlepd_out_buf
//
// Usage:
//   i_char carries one pattern character per transaction, with first marking
//   the opening character of a new pattern. o_run carries one run of live
//   cells (row, start column, clipped length) for each run character that
//   lands inside the grid. i_cfg writes row_limit (index 0) and column_limit
//   (index 1); it is always ready and should only be used while idle.
//   A run is registered into the result buffer, behind any waiting run.
//   Throughput: one character per cycle while the result buffer is not full;
//   the decode is a single pass from the state registers to the result buffer.
//   The result side has an output register and a skid entry, so a character
//   is still taken while one run waits; i_char.ready drops only when both
//   entries are full and returns the cycle after a run is taken from o_run.
//   Reset clears the limits, the pattern state and the result count, not the entries.
module rle_pattern_run_decoder import rlepd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlepd_char_if.sink  i_char,
    rlepd_run_if.source o_run,
    rlepd_cfg_if.sink   i_cfg
);

    logic [LIMIT_W-1:0] r_row_limit;
    logic [LIMIT_W-1:0] r_column_limit;
    logic               char_accept;
    logic               run_pop;
    logic               buf_full;
    t_step_result       step_result;
    t_run               head_run;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit    <= '0;
            r_column_limit <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_LIMIT:    r_row_limit    <= i_cfg.data;
                REG_COLUMN_LIMIT: r_column_limit <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // handshakes
    assign i_char.ready = !buf_full;
    assign char_accept  = i_char.valid && !buf_full;
    assign run_pop      = o_run.valid && o_run.ready;

    rlepd_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (char_accept),
        .i_char_code    (i_char.char_code),
        .i_first        (i_char.first),
        .i_row_limit    (r_row_limit),
        .i_column_limit (r_column_limit),
        .o_result       (step_result)
    );

    rlepd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (char_accept && step_result.produce),
        .i_data  (step_result.run),
        .i_pop   (run_pop),
        .o_valid (o_run.valid),
        .o_full  (buf_full),
        .o_data  (head_run)
    );

    assign o_run.run_row    = head_run.run_row;
    assign o_run.run_column = head_run.run_column;
    assign o_run.run_length = head_run.run_length;

endmodule

// ===== hdl/rlepd_checker.sv =====
// port-level checks for the run-length pattern decoder, bound to the top level
// depends on rlepd_pkg and rle_pattern_run_decoder
module rlepd_checker import rlepd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_run_row,
    input logic [OUT_W-1:0] i_run_column,
    input logic [OUT_W-1:0] i_run_length
);

    // reset empties the result buffer and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("result buffer not empty after reset");

    // a clipped run is never empty
    a_nonzero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_run_length != '0))
        else $error("run of zero length delivered");

    // a pending run stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("run dropped while stalled");

    // a pending run keeps its payload
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_run_row) && $stable(i_run_column) && $stable(i_run_length)))
        else $error("run payload changed while stalled");

endmodule

bind rle_pattern_run_decoder rlepd_checker u_rlepd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_char.ready),
    .i_out_valid  (o_run.valid),
    .i_out_ready  (o_run.ready),
    .i_run_row    (o_run.run_row),
    .i_run_column (o_run.run_column),
    .i_run_length (o_run.run_length)
);
